FILE: hdl/pcgrvu_pkg.sv
// pcgrvu_pkg: operation codes, register indexes, reset values, FSM states and
// the XSH-RR output and sign hash functions for the PCG32 random variate unit.
// No dependencies.
`default_nettype none

package pcgrvu_pkg;

  // operation codes
  localparam logic [2:0] OP_SEED = 3'd0;
  localparam logic [2:0] OP_RAW  = 3'd1;
  localparam logic [2:0] OP_BERN = 3'd2;
  localparam logic [2:0] OP_GEOM = 3'd3;
  localparam logic [2:0] OP_UNIF = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_MULT = 3'd0;
  localparam logic [2:0] CFG_INCR = 3'd1;
  localparam logic [2:0] CFG_BTHR = 3'd2;
  localparam logic [2:0] CFG_GTHR = 3'd3;
  localparam logic [2:0] CFG_GLIM = 3'd4;

  localparam logic [63:0] MULT_RESET = 64'd6364136223846793005;
  localparam logic [63:0] INCR_RESET = 64'd1442695040888963407;
  localparam logic [32:0] THR_RESET  = 33'h080000000;
  localparam logic [15:0] GLIM_RESET = 16'd15;

  // total draws one geometric item may make
  localparam int unsigned GEOM_DRAW_BUDGET = 65536;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAW,
    S_FIN
  } state_t;

  typedef struct packed {
    logic        start;
    logic        seed;
  } draw_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] word;
    logic        sign;
  } draw_rsp_t;

  // XSH-RR: xorshift high bits, then rotate right by the top five state bits
  function automatic logic [31:0] xsh_rr(input logic [63:0] s);
    logic [63:0] t;
    logic [31:0] x;
    logic [4:0]  r;
    logic [63:0] xx;
    t  = (s >> 18) ^ s;
    x  = t[58:27];
    r  = s[63:59];
    xx = {x, x} >> r;
    return xx[31:0];
  endfunction

  // sign hash of the old state: negative when bit 31 of the hash is clear
  function automatic logic neg_hash(input logic [63:0] s);
    logic [31:0] h;
    h = s[31:0] ^ {s[18:0], 13'b0};
    h = h ^ (h >> 17);
    h = h ^ (h << 19);
    return ~h[31];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pcgrvu_ifs.sv
// pcgrvu_req_if / pcgrvu_rsp_if: valid/ready channels for request and result items.
// No dependencies.
`default_nettype none

interface pcgrvu_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [63:0] seed_value;
  modport source (output valid, operation, seed_value, input ready);
  modport sink (input valid, operation, seed_value, output ready);
endinterface

interface pcgrvu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        negative;
  modport source (output valid, value, negative, input ready);
  modport sink (input valid, value, negative, output ready);
endinterface

`default_nettype wire

FILE: hdl/pcgrvu_draw_unit.sv
// pcgrvu_draw_unit: generator state and the shared 32x32 multiplier that
// advances it in four phases per draw. Depends on pcgrvu_pkg.
`default_nettype none

module pcgrvu_draw_unit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire pcgrvu_pkg::draw_req_t dreq,
  input  wire logic [63:0]           seed_value,
  input  wire logic [63:0]           mult,
  input  wire logic [63:0]           incr,
  output pcgrvu_pkg::draw_rsp_t      drsp
);
  import pcgrvu_pkg::*;

  logic [63:0] gen_state;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] word;
  logic        sign;
  logic        busy;
  logic [1:0]  ph;
  logic        done;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  assign done = busy && (ph == 2'd3);

  // state*mult mod 2^64 = lo*lo + ((lo*hi + hi*lo) << 32)
  assign mul_a = (ph == 2'd2) ? gen_state[63:32] : gen_state[31:0];
  assign mul_b = (ph == 2'd1) ? mult[63:32] : mult[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      ph        <= 2'd0;
      gen_state <= 64'd0;
    end else begin
      if (dreq.start && (!busy || done)) begin
        busy <= 1'b1;
        ph   <= 2'd0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (busy) begin
        ph <= ph + 2'd1;
      end
      if (dreq.seed) begin
        gen_state <= seed_value;
      end else if (done) begin
        gen_state <= {acc[63:32] + prod[31:0], acc[31:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      prod <= 64'(mul_a) * 64'(mul_b);
      case (ph)
        2'd0: begin
          word <= xsh_rr(gen_state);
          sign <= neg_hash(gen_state);
        end
        2'd1: acc <= prod + incr;
        2'd2: acc[63:32] <= acc[63:32] + prod[31:0];
        default: ;
      endcase
    end
  end

  assign drsp.done = done;
  assign drsp.word = word;
  assign drsp.sign = sign;

endmodule

`default_nettype wire

FILE: hdl/pcgrvu_seq.sv
// pcgrvu_seq: request sequencer, geometric retry logic and result register.
// Depends on pcgrvu_pkg and the channel interfaces.
`default_nettype none

module pcgrvu_seq #(
  parameter int LIMIT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  pcgrvu_req_if.sink                 req,
  pcgrvu_rsp_if.source               rsp,
  input  wire logic [32:0]           bthr,
  input  wire logic [32:0]           gthr,
  input  wire logic [15:0]           glim,
  input  wire pcgrvu_pkg::draw_rsp_t drsp,
  output pcgrvu_pkg::draw_req_t      dreq
);
  import pcgrvu_pkg::*;

  localparam int KW     = LIMIT_BITS + 1;
  localparam int USED_W = $clog2(GEOM_DRAW_BUDGET + 1);

  state_t              st;
  state_t              st_next;
  logic [2:0]          op;
  logic [KW-1:0]       k;
  logic [USED_W-1:0]   used;
  logic [31:0]         pend_value;
  logic                pend_neg;
  logic                out_valid;
  logic [31:0]         out_value;
  logic                out_neg;

  logic                accept;
  logic                is_draw_op;
  logic [LIMIT_BITS+15:0] lim_ext;
  logic [LIMIT_BITS-1:0]  limit;
  logic [KW-1:0]       limit_p1;
  logic [32:0]         d33;
  logic                hit_g;
  logic                k_in;
  logic                geom_ok;
  logic                budget_out;
  logic                fin_now;
  logic [KW-1:0]       k_next;
  logic [31:0]         res_value;
  logic                slot_free;
  logic                load_out;

  assign accept     = req.valid && req.ready;
  assign is_draw_op = req.operation inside {OP_RAW, OP_BERN, OP_GEOM, OP_UNIF};
  assign lim_ext    = {{LIMIT_BITS{1'b0}}, glim};
  assign limit      = lim_ext[LIMIT_BITS-1:0];
  assign limit_p1   = {1'b0, limit} + KW'(1);
  assign d33        = {1'b0, drsp.word};
  assign hit_g      = d33 <= gthr;
  assign k_in       = k <= {1'b0, limit};
  assign geom_ok    = hit_g && k_in;
  assign budget_out = used == USED_W'(GEOM_DRAW_BUDGET - 1);
  assign fin_now    = (op != OP_GEOM) || geom_ok || budget_out;
  assign slot_free  = !out_valid || rsp.ready;

  always_comb begin
    if (hit_g) begin
      k_next = '0;
    end else if (k_in) begin
      k_next = KW'(k + KW'(1));
    end else begin
      k_next = k;
    end
  end

  always_comb begin
    case (op)
      OP_RAW:  res_value = drsp.word;
      OP_BERN: res_value = {31'd0, d33 <= bthr};
      OP_GEOM: res_value = geom_ok ? 32'(k) : 32'(limit_p1);
      OP_UNIF: res_value = drsp.word;
      default: res_value = 32'd0;
    endcase
  end

  // next state
  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: begin
        if (accept) st_next = is_draw_op ? S_DRAW : S_FIN;
      end
      S_DRAW: begin
        if (drsp.done && fin_now) st_next = S_FIN;
      end
      S_FIN: begin
        if (slot_free) st_next = S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready  = 1'b0;
    dreq.start = 1'b0;
    dreq.seed  = 1'b0;
    load_out   = 1'b0;
    case (st)
      S_IDLE: begin
        req.ready  = 1'b1;
        dreq.start = req.valid && is_draw_op;
        dreq.seed  = req.valid && (req.operation == OP_SEED);
      end
      S_DRAW: begin
        dreq.start = drsp.done && !fin_now;  // next geometric draw, back to back
      end
      S_FIN: begin
        load_out = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= req.operation;
      k          <= '0;
      used       <= '0;
      pend_value <= 32'd0;
      pend_neg   <= 1'b0;
    end else if (st == S_DRAW && drsp.done) begin
      used <= USED_W'(used + USED_W'(1));
      k    <= k_next;
      if (fin_now) begin
        pend_value <= res_value;
        pend_neg   <= (op == OP_UNIF) && drsp.sign;
      end
    end
    if (load_out) begin
      out_value <= pend_value;
      out_neg   <= pend_neg;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.value    = out_value;
  assign rsp.negative = out_neg;

endmodule

`default_nettype wire

FILE: hdl/pcg32_random_variate_unit_core.sv
// pcg32_random_variate_unit_core: top level with configuration registers,
// sequencer and draw unit. Depends on pcgrvu_pkg, the channel interfaces,
// pcgrvu_draw_unit and pcgrvu_seq.
//
//   channel   dir  handshake      payload
//   req       in   valid/ready    operation[2:0], seed_value[63:0]
//   rsp       out  valid/ready    value[31:0], negative
//   cfg       in   cfg_we         cfg_index[2:0], cfg_data[63:0]
//
// Each draw's 64-bit state update runs three 32x32 products through the single
// shared multiplier. Raw, Bernoulli and uniform items make one draw; seed and
// unused codes make none; a geometric item makes up to 65536 draws, back to back.
// req.ready is high only while idle. The result register holds an item for
// rsp while the next request is accepted. rst is synchronous; it clears the
// control and generator state and loads the configuration reset values.
`default_nettype none

module pcg32_random_variate_unit_core #(
  parameter int LIMIT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  pcgrvu_req_if.sink       req,
  pcgrvu_rsp_if.source     rsp,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import pcgrvu_pkg::*;

  logic [63:0] mult;
  logic [63:0] incr;
  logic [32:0] bthr;
  logic [32:0] gthr;
  logic [15:0] glim;
  draw_req_t   dreq;
  draw_rsp_t   drsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      mult <= MULT_RESET;
      incr <= INCR_RESET;
      bthr <= THR_RESET;
      gthr <= THR_RESET;
      glim <= GLIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MULT: mult <= cfg_data;
        CFG_INCR: incr <= cfg_data;
        CFG_BTHR: bthr <= cfg_data[32:0];
        CFG_GTHR: gthr <= cfg_data[32:0];
        CFG_GLIM: glim <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  pcgrvu_draw_unit u_draw (
    .clk        (clk),
    .rst        (rst),
    .dreq       (dreq),
    .seed_value (req.seed_value),
    .mult       (mult),
    .incr       (incr),
    .drsp       (drsp)
  );

  pcgrvu_seq #(
    .LIMIT_BITS (LIMIT_BITS)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .bthr (bthr),
    .gthr (gthr),
    .glim (glim),
    .drsp (drsp),
    .dreq (dreq)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while previous item in progress");

  a_done_not_idle: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> !req.ready)
    else $error("draw finished while sequencer idle");

  a_seed_xor_start: assert property (@(posedge clk) disable iff (rst)
    !(dreq.seed && dreq.start))
    else $error("seed and draw issued together");

endmodule

`default_nettype wire
